[rtl/tgc_pkg.sv]
package tgc_pkg;

    localparam int TIME_W      = 32;
    localparam int THRESH_W    = 16;
    localparam int DRAG_W      = 24;
    localparam int EVT_COORD_W = 12;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_THRESH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG_DIST   = 8'd1;

    localparam logic [THRESH_W-1:0] LONG_THRESH_RST = 16'd500;
    localparam logic [DRAG_W-1:0]   DRAG_DIST_RST   = 24'd100;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_LONG    = 2'd1,
        KIND_DRAG    = 2'd2,
        KIND_RELEASE = 2'd3
    } t_tgc_kind;

    typedef struct packed {
        logic [THRESH_W-1:0] long_thresh;
        logic [DRAG_W-1:0]   drag_dist;
    } t_tgc_cfg;

    typedef struct packed {
        t_tgc_kind              kind;
        logic [EVT_COORD_W-1:0] x;
        logic [EVT_COORD_W-1:0] y;
        logic [TIME_W-1:0]      dur;
    } t_tgc_event;

endpackage

[rtl/tgc_sample_if.sv]
interface tgc_sample_if #(
    parameter int COORD_BITS = 12
);
    logic                      valid;
    logic                      ready;
    logic                      touch_active;
    logic [COORD_BITS-1:0]     pos_x;
    logic [COORD_BITS-1:0]     pos_y;
    logic [tgc_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, output touch_active, output pos_x, output pos_y,
                    output now_ms, input ready);
    modport sink   (input valid, input touch_active, input pos_x, input pos_y,
                    input now_ms, output ready);
endinterface

[rtl/tgc_event_if.sv]
interface tgc_event_if;
    logic                            valid;
    logic                            ready;
    tgc_pkg::t_tgc_kind              event_kind;
    logic [tgc_pkg::EVT_COORD_W-1:0] event_x;
    logic [tgc_pkg::EVT_COORD_W-1:0] event_y;
    logic [tgc_pkg::TIME_W-1:0]      duration_ms;

    modport source (output valid, output event_kind, output event_x, output event_y,
                    output duration_ms, input ready);
    modport sink   (input valid, input event_kind, input event_x, input event_y,
                    input duration_ms, output ready);
endinterface

[rtl/tgc_engine.sv]
module tgc_engine #(
    parameter int COORD_BITS = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic                       i_touch_active,
    input  logic [COORD_BITS-1:0]      i_pos_x,
    input  logic [COORD_BITS-1:0]      i_pos_y,
    input  logic [tgc_pkg::TIME_W-1:0] i_now_ms,
    input  tgc_pkg::t_tgc_cfg          i_cfg,
    output logic                       o_has,
    output tgc_pkg::t_tgc_event        o_evt
);
    import tgc_pkg::*;

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 1;
    localparam int CMP_W = (SUM_W > DRAG_W) ? SUM_W : DRAG_W;

    logic                  r_in_contact, n_in_contact;
    logic                  r_long_fired, n_long_fired;
    logic [TIME_W-1:0]     r_start_time, n_start_time;
    logic [COORD_BITS-1:0] r_start_x,    n_start_x;
    logic [COORD_BITS-1:0] r_start_y,    n_start_y;

    logic [TIME_W-1:0]             w_dur;
    logic [COORD_BITS-1:0]         w_dx, w_dy;
    logic [SQ_W-1:0]               w_dxe, w_dye, w_sq_x, w_sq_y;
    logic [SUM_W-1:0]              w_sum;
    logic [CMP_W+SUM_W-1:0]        w_sum_pad;
    logic [CMP_W+DRAG_W-1:0]       w_lim_pad;
    logic [CMP_W-1:0]              w_sum_c, w_lim_c;
    logic                          w_drag;
    logic                          w_long_due;
    logic [EVT_COORD_W+COORD_BITS-1:0] w_x_pad, w_y_pad, w_sx_pad, w_sy_pad;

    assign w_dur = i_now_ms - r_start_time;

    assign w_dx   = (i_pos_x >= r_start_x) ? (i_pos_x - r_start_x) : (r_start_x - i_pos_x);
    assign w_dy   = (i_pos_y >= r_start_y) ? (i_pos_y - r_start_y) : (r_start_y - i_pos_y);
    assign w_dxe  = {{COORD_BITS{1'b0}}, w_dx};
    assign w_dye  = {{COORD_BITS{1'b0}}, w_dy};
    assign w_sq_x = w_dxe * w_dxe;
    assign w_sq_y = w_dye * w_dye;
    assign w_sum  = {1'b0, w_sq_x} + {1'b0, w_sq_y};

    assign w_sum_pad = {{CMP_W{1'b0}}, w_sum};
    assign w_lim_pad = {{CMP_W{1'b0}}, i_cfg.drag_dist};
    assign w_sum_c   = w_sum_pad[CMP_W-1:0];
    assign w_lim_c   = w_lim_pad[CMP_W-1:0];
    assign w_drag    = w_sum_c > w_lim_c;

    assign w_long_due = !r_long_fired && (w_dur >= {{(TIME_W-THRESH_W){1'b0}}, i_cfg.long_thresh});

    assign w_x_pad  = {{EVT_COORD_W{1'b0}}, i_pos_x};
    assign w_y_pad  = {{EVT_COORD_W{1'b0}}, i_pos_y};
    assign w_sx_pad = {{EVT_COORD_W{1'b0}}, r_start_x};
    assign w_sy_pad = {{EVT_COORD_W{1'b0}}, r_start_y};

    always_comb begin
        n_in_contact = r_in_contact;
        n_long_fired = r_long_fired;
        n_start_time = r_start_time;
        n_start_x    = r_start_x;
        n_start_y    = r_start_y;
        o_has        = 1'b0;
        o_evt.kind   = KIND_PRESS;
        o_evt.x      = w_x_pad[EVT_COORD_W-1:0];
        o_evt.y      = w_y_pad[EVT_COORD_W-1:0];
        o_evt.dur    = w_dur;
        if (i_touch_active) begin
            if (!r_in_contact) begin
                n_in_contact = 1'b1;
                n_long_fired = 1'b0;
                n_start_time = i_now_ms;
                n_start_x    = i_pos_x;
                n_start_y    = i_pos_y;
                o_has        = 1'b1;
                o_evt.dur    = '0;
            end else begin
                if (w_long_due) begin
                    n_long_fired = 1'b1;
                    o_evt.kind   = KIND_LONG;
                    o_has        = 1'b1;
                end
                if (w_drag) begin
                    o_evt.kind = KIND_DRAG;
                    o_has      = 1'b1;
                end
            end
        end else if (r_in_contact) begin
            n_in_contact = 1'b0;
            o_has        = 1'b1;
            o_evt.kind   = KIND_RELEASE;
            o_evt.x      = w_sx_pad[EVT_COORD_W-1:0];
            o_evt.y      = w_sy_pad[EVT_COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_contact <= 1'b0;
            r_long_fired <= 1'b0;
            r_start_time <= '0;
            r_start_x    <= '0;
            r_start_y    <= '0;
        end else if (i_fire) begin
            r_in_contact <= n_in_contact;
            r_long_fired <= n_long_fired;
            r_start_time <= n_start_time;
            r_start_x    <= n_start_x;
            r_start_y    <= n_start_y;
        end
    end

    a_release_on_lift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_touch_active && r_in_contact) |-> (o_has && o_evt.kind == KIND_RELEASE))
        else $error("contact ended without a release event");

    a_press_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_touch_active && !r_in_contact)
            |=> (r_in_contact && !r_long_fired && r_start_time == $past(i_now_ms)))
        else $error("press did not capture the start of contact");

    a_long_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_has && o_evt.kind == KIND_LONG) |=> r_long_fired)
        else $error("long press reported without setting the fired flag");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_in_contact) && $stable(r_long_fired) && $stable(r_start_time)))
        else $error("touch state changed without a consumed sample");

endmodule

[rtl/touch_gesture_classifier_core.sv]
// Touch gesture classifier.
// Touch poll samples arrive as beats on i_sample (contact flag, position,
// millisecond timestamp); gesture events leave as beats on o_event
// (press, long press, drag or release, with position and held duration).
// A sample that causes no gesture produces no output beat.
// The two thresholds are written through i_cfg_we / i_cfg_idx / i_cfg_data
// by the user only while the block is idle (the block does not enforce it);
// writes to unknown indexes are ignored. A sample beat is captured in the
// input register and classified into the result register feeding o_event.
// Throughput is one sample per cycle while the receiver does not stall; the
// classifier state update and squared-distance compare are combinational.
// When the receiver stalls, the event is held in the result register and a
// further sample can still sit in the input register; i_sample.ready falls
// only once both are occupied.
// Reset clears the pipeline, ends any touch in progress and restores the
// thresholds to 500 ms and 100 squared pixels.
module touch_gesture_classifier_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tgc_sample_if.sink                          i_sample,
    tgc_event_if.source                         o_event,
    input  logic                                i_cfg_we,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tgc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import tgc_pkg::*;

    t_tgc_cfg              r_cfg;

    logic                  r_in_valid;
    logic                  r_in_touch;
    logic [COORD_BITS-1:0] r_in_x;
    logic [COORD_BITS-1:0] r_in_y;
    logic [TIME_W-1:0]     r_in_now;

    logic                  r_out_valid;
    t_tgc_event            r_out_evt;

    logic                  w_advance;
    logic                  w_fire;
    logic                  w_has;
    t_tgc_event            w_evt;

    assign w_advance      = !r_out_valid || o_event.ready;
    assign w_fire         = r_in_valid && w_advance;
    assign i_sample.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_thresh <= LONG_THRESH_RST;
            r_cfg.drag_dist   <= DRAG_DIST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LONG_THRESH: r_cfg.long_thresh <= i_cfg_data[THRESH_W-1:0];
                CFG_DRAG_DIST:   r_cfg.drag_dist   <= i_cfg_data[DRAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_in_touch <= i_sample.touch_active;
            r_in_x     <= i_sample.pos_x;
            r_in_y     <= i_sample.pos_y;
            r_in_now   <= i_sample.now_ms;
        end
    end

    tgc_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_touch_active (r_in_touch),
        .i_pos_x        (r_in_x),
        .i_pos_y        (r_in_y),
        .i_now_ms       (r_in_now),
        .i_cfg          (r_cfg),
        .o_has          (w_has),
        .o_evt          (w_evt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_fire && w_has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_has) begin
            r_out_evt <= w_evt;
        end
    end

    assign o_event.valid       = r_out_valid;
    assign o_event.event_kind  = r_out_evt.kind;
    assign o_event.event_x     = r_out_evt.x;
    assign o_event.event_y     = r_out_evt.y;
    assign o_event.duration_ms = r_out_evt.dur;

    a_press_zero_dur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_evt.kind == KIND_PRESS) |-> (r_out_evt.dur == '0))
        else $error("press event with nonzero duration");

    a_no_fire_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_event.ready) |-> !w_fire)
        else $error("sample consumed while the result register is blocked");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_event.ready) |-> !i_sample.ready)
        else $error("input accepted with both stages occupied and stalled");

endmodule
